FILE: design/pif_pkg.sv
// Shared types, codes and character constants for the printf integer formatter.
package pif_pkg;

  localparam int VALUE_W        = 64;
  localparam int DIGITS         = 22;   // octal digits of a 64-bit value, the most of any base
  localparam int DIG_CNT_W      = $clog2(DIGITS + 1);
  localparam int MAX_FIELD_DEF  = 28;
  localparam int PTR_DIGITS_DEF = 16;

  localparam logic [2:0] FUNC_D  = 3'd0;
  localparam logic [2:0] FUNC_U  = 3'd1;
  localparam logic [2:0] FUNC_X  = 3'd2;
  localparam logic [2:0] FUNC_UX = 3'd3;
  localparam logic [2:0] FUNC_O  = 3'd4;
  localparam logic [2:0] FUNC_P  = 3'd5;

  localparam logic [1:0] SMODE_PLUS  = 2'd1;
  localparam logic [1:0] SMODE_SPACE = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA10  = 8'h61 - 8'd10;
  localparam logic [7:0] CH_UA10  = 8'h41 - 8'd10;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_HEX,
    BASE_OCT
  } base_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [63:0] value;
    logic        wide;
    logic        alternate;
    logic        left_align;
    logic [1:0]  sign_mode;
    logic        zero_fill;
    logic [4:0]  width;
    logic [4:0]  precision;
  } req_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } res_word_t;

  typedef struct packed {
    logic               start;
    base_t              base;
    logic [VALUE_W-1:0] mag;
    logic               pop;
  } pif_dig_ctl_t;

  typedef struct packed {
    logic                 hold;
    logic [3:0]           top;
    logic [DIG_CNT_W-1:0] ndig;
  } pif_dig_sts_t;

endpackage

FILE: design/pif_digits.sv
// Digit stack: bit-serial binary to BCD, direct hex/octal load, leading-zero trim, MSD-first pop.
module pif_digits
  import pif_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  pif_dig_ctl_t ctl,
  output pif_dig_sts_t sts
);

  localparam int HEX_W  = 4 * DIGITS;
  localparam int OCT_W  = 3 * DIGITS;
  localparam int BCNT_W = $clog2(VALUE_W + 1);

  typedef enum logic [1:0] {
    D_IDLE,
    D_CONV,
    D_TRIM,
    D_HOLD
  } dstate_t;

  dstate_t              state;
  logic [3:0]           dig [DIGITS];
  logic [3:0]           adj [DIGITS];
  logic [3:0]           ld  [DIGITS];
  logic [VALUE_W-1:0]   sh;
  logic [BCNT_W-1:0]    bitcnt;
  logic [DIG_CNT_W-1:0] ndig;
  logic [HEX_W-1:0]     mag_hex;
  logic [OCT_W-1:0]     mag_oct;

  always_comb begin
    mag_hex = HEX_W'(ctl.mag);
    mag_oct = OCT_W'(ctl.mag);
    for (int i = 0; i < DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
      if (ctl.base == BASE_OCT) begin
        ld[i] = {1'b0, mag_oct[3*i +: 3]};
      end else if (ctl.base == BASE_HEX) begin
        ld[i] = mag_hex[4*i +: 4];
      end else begin
        ld[i] = 4'd0;
      end
    end
  end

  assign sts.hold = (state == D_HOLD);
  assign sts.top  = dig[DIGITS-1];
  assign sts.ndig = ndig;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE, D_HOLD: begin
          if (ctl.start) begin
            for (int i = 0; i < DIGITS; i++) dig[i] <= ld[i];
            sh     <= ctl.mag;
            bitcnt <= BCNT_W'(VALUE_W);
            ndig   <= DIG_CNT_W'(DIGITS);
            state  <= (ctl.base == BASE_DEC) ? D_CONV : D_TRIM;
          end else if (ctl.pop) begin
            for (int i = DIGITS - 1; i > 0; i--) dig[i] <= dig[i-1];
            dig[0] <= 4'd0;
          end
        end
        D_CONV: begin
          // double dabble: add 3 to digits of 5 or more, then shift one bit in
          dig[0] <= {adj[0][2:0], sh[VALUE_W-1]};
          for (int i = 1; i < DIGITS; i++) dig[i] <= {adj[i][2:0], adj[i-1][3]};
          sh     <= {sh[VALUE_W-2:0], 1'b0};
          bitcnt <= bitcnt - BCNT_W'(1);
          if (bitcnt == BCNT_W'(1)) state <= D_TRIM;
        end
        D_TRIM: begin
          if (ndig > DIG_CNT_W'(1) && dig[DIGITS-1] == 4'd0) begin
            for (int i = DIGITS - 1; i > 0; i--) dig[i] <= dig[i-1];
            dig[0] <= 4'd0;
            ndig   <= ndig - DIG_CNT_W'(1);
          end else begin
            state <= D_HOLD;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_hold_ndig: assert property (@(posedge clk) disable iff (rst)
    (state == D_HOLD) |-> (ndig != '0))
    else $error("digit stack holds an empty number");
  a_pop_hold: assert property (@(posedge clk) disable iff (rst)
    (ctl.pop && !ctl.start) |-> (state == D_HOLD))
    else $error("digit pop outside hold");
  a_conv_end: assert property (@(posedge clk) disable iff (rst)
    (state == D_CONV && bitcnt == BCNT_W'(1)) |=> (state == D_TRIM))
    else $error("conversion did not move to trim");
`endif

endmodule

FILE: design/printf_integer_formatter.sv
// Top level of the printf-style integer formatter: request decode, field layout, character output.
//
// Usage:
//   One request word (req) describes one integer conversion: kind, value bits
//   and the printf flags. It is taken when req_valid is high and req_stall low.
//   The block returns the characters of the formatted field one word per
//   character on res, with last set on the final one. Unused kinds (6, 7)
//   give no characters.
// Timing:
//   One request at a time; req_stall is high from the cycle after acceptance
//   through the edge that loads the last character into the output register.
//   Decimal values go through bit-serial BCD conversion; hex, octal and pointer
//   values load straight into the digit stack at acceptance. Leading zeros are
//   then trimmed (at most 21 dropped), the field is laid out in ST_SETUP1 and
//   ST_SETUP2, and the characters are sent last (up to 31 by default).
// Reset: rst (synchronous) returns the sequencer and digit stack to idle and
//   drops res_valid; any conversion in flight is discarded.
// Backpressure: while res_stall is high a valid output word holds and character
//   generation pauses; nothing is lost.
module printf_integer_formatter
  import pif_pkg::*;
#(
  parameter int MAX_FIELD      = MAX_FIELD_DEF,
  parameter int POINTER_DIGITS = PTR_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  req_word_t req,
  input  logic      req_valid,
  output logic      req_stall,
  output res_word_t res,
  output logic      res_valid,
  input  logic      res_stall
);

  // longest field: widest of width and digit run, plus prefix and sign
  localparam int TOT_MAX = ((MAX_FIELD > DIGITS) ? MAX_FIELD : DIGITS) + 3;
  localparam int CW      = $clog2(TOT_MAX + 1);
  localparam logic [VALUE_W-1:0] PTR_MASK = (4 * POINTER_DIGITS >= VALUE_W) ? '1 :
                                            ((VALUE_W'(1) << (4 * POINTER_DIGITS)) - VALUE_W'(1));

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SETUP1,
    ST_SETUP2,
    ST_EMIT
  } state_t;

  state_t       state;
  pif_dig_ctl_t ctl;
  pif_dig_sts_t sts;

  // decoded request, held for the conversion
  logic          neg, upper, alt, left, zp, ptr;
  base_t         base;
  logic [1:0]    smode;
  logic [CW-1:0] w, prec;

  // emission counters
  logic          sgn;
  logic [1:0]    pfx;
  logic [CW-1:0] zc, dc, padl, padr, tot;

  // request decode
  logic               accept, is_ptr, is_neg, func_ok;
  logic [VALUE_W-1:0] v_sel, v_neg;
  base_t              base_in;
  logic [CW-1:0]      w_in, p_in;

  always_comb begin
    accept  = req_valid && !req_stall;
    func_ok = (req.func <= FUNC_P);
    is_ptr  = (req.func == FUNC_P);
    if (is_ptr) begin
      v_sel = req.value & PTR_MASK;
    end else if (req.wide) begin
      v_sel = req.value;
    end else begin
      v_sel = {32'd0, req.value[31:0]};
    end
    is_neg = (req.func == FUNC_D) && (req.wide ? req.value[63] : req.value[31]);
    v_neg  = VALUE_W'(0) - v_sel;
    if (!req.wide) v_neg = {32'd0, v_neg[31:0]};
    unique case (req.func)
      FUNC_X, FUNC_UX, FUNC_P: base_in = BASE_HEX;
      FUNC_O:                  base_in = BASE_OCT;
      default:                 base_in = BASE_DEC;
    endcase
    w_in = (CW'(req.width) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(req.width);
    p_in = (CW'(req.precision) > CW'(MAX_FIELD)) ? CW'(MAX_FIELD) : CW'(req.precision);
  end

  assign req_stall = (state != ST_IDLE);

  // layout arithmetic
  logic [1:0]    pl;
  logic          sl;
  logic [CW-1:0] nd, rsv, z, n_len, pad;

  always_comb begin
    nd = CW'(sts.ndig);
    if (alt && base == BASE_HEX) begin
      pl = 2'd2;
    end else if (alt && base == BASE_OCT) begin
      pl = 2'd1;
    end else begin
      pl = 2'd0;
    end
    sl  = neg || smode == SMODE_PLUS || smode == SMODE_SPACE;
    rsv = CW'(pl) + CW'(neg) + nd;
    if (prec != '0) begin
      z = (prec > nd) ? prec - nd : '0;
    end else if (w != '0 && zp) begin
      z = (w > rsv) ? w - rsv : '0;
    end else begin
      z = '0;
    end
    n_len = CW'(sgn) + CW'(pfx) + zc + dc;
    pad   = (!ptr && w > n_len) ? w - n_len : '0;
  end

  // character select, in field order
  logic       load, take_padl, take_sgn, take_pfx, take_zero, take_dig;
  logic [7:0] ch;

  always_comb begin
    load      = (state == ST_EMIT) && (!res_valid || !res_stall);
    take_padl = (padl != '0);
    take_sgn  = !take_padl && sgn;
    take_pfx  = !take_padl && !sgn && (pfx != 2'd0);
    take_zero = !take_padl && !sgn && (pfx == 2'd0) && (zc != '0);
    take_dig  = !take_padl && !sgn && (pfx == 2'd0) && (zc == '0) && (dc != '0);
    if (take_padl) begin
      ch = CH_SPACE;
    end else if (take_sgn) begin
      ch = neg ? CH_MINUS : ((smode == SMODE_PLUS) ? CH_PLUS : CH_SPACE);
    end else if (take_pfx) begin
      if (pfx == 2'd1 && base == BASE_HEX) begin
        ch = upper ? CH_UX : CH_LX;
      end else begin
        ch = CH_ZERO;
      end
    end else if (take_zero) begin
      ch = CH_ZERO;
    end else if (take_dig) begin
      if (sts.top < 4'd10) begin
        ch = CH_ZERO + {4'd0, sts.top};
      end else begin
        ch = (upper ? CH_UA10 : CH_LA10) + {4'd0, sts.top};
      end
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    ctl.start = accept && func_ok;
    ctl.base  = base_in;
    ctl.mag   = is_neg ? v_neg : v_sel;
    ctl.pop   = load && take_dig;
  end

  pif_digits u_digits (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && func_ok) begin
            neg   <= is_neg;
            upper <= (req.func == FUNC_UX);
            base  <= base_in;
            ptr   <= is_ptr;
            alt   <= is_ptr ? 1'b1 : req.alternate;
            left  <= req.left_align;
            smode <= req.sign_mode;
            zp    <= req.zero_fill;
            w     <= is_ptr ? '0 : w_in;
            prec  <= is_ptr ? CW'(POINTER_DIGITS) : p_in;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (sts.hold) state <= ST_SETUP1;
        end
        ST_SETUP1: begin
          pfx   <= pl;
          sgn   <= sl;
          zc    <= z;
          dc    <= nd;
          state <= ST_SETUP2;
        end
        ST_SETUP2: begin
          padl  <= left ? '0 : pad;
          padr  <= left ? pad : '0;
          tot   <= n_len + pad;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (load) begin
            res.char_out <= ch;
            res.last     <= (tot == CW'(1));
            tot          <= tot - CW'(1);
            if (take_padl) begin
              padl <= padl - CW'(1);
            end else if (take_sgn) begin
              sgn <= 1'b0;
            end else if (take_pfx) begin
              pfx <= pfx - 2'd1;
            end else if (take_zero) begin
              zc <= zc - CW'(1);
            end else if (take_dig) begin
              dc <= dc - CW'(1);
            end else begin
              padr <= padr - CW'(1);
            end
            if (tot == CW'(1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (tot != '0))
    else $error("emitting with no characters left");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && tot == CW'(1)) |=> (state == ST_IDLE && res_valid && res.last))
    else $error("final character did not end the conversion");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (dc != '0 && sts.hold))
    else $error("digit pop with no digit pending");
`endif

endmodule

FILE: test/tb_top.sv
// Testbench for the printf integer formatter: directed table, random requests, char scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import pif_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  req_word_t req = '0;
  logic      req_valid = 1'b0;
  logic      req_stall;
  res_word_t res;
  logic      res_valid;
  logic      res_stall = 1'b0;

  printf_integer_formatter DUT (
    .clk(clk), .rst(rst), .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .res(res), .res_valid(res_valid), .res_stall(res_stall)
  );

  always #5 clk = ~clk;

  localparam int MAXF = MAX_FIELD_DEF;
  localparam int PDIG = PTR_DIGITS_DEF;
  localparam int RANDOM_ITEMS = 356;
  localparam int CYCLE_LIMIT = 2000000;

  res_word_t expected_chars[$];
  int        errors = 0;
  int        cycles = 0;
  bit        stim_done = 0;
  bit        hold_long = 0;   // forces a long receiver hold-off

  // One directed row: request plus an optional typed-in text (empty means
  // use the predictor).
  typedef struct {
    req_word_t r;
    string     txt;
  } row_t;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int clip_field(input logic [4:0] raw);
    return (raw > MAXF) ? MAXF : int'(raw);
  endfunction

  // Predicts the characters of one conversion and appends them to the queue.
  task automatic format_chars(input req_word_t r);
    logic [63:0] v;
    logic [7:0]  body[0:127];
    int n, w, prec, pad, base, target;
    bit  alt, neg, upper, ptr;
    res_word_t c;
    logic [7:0] d;
    int k0;
    v = r.value; n = 0; pad = 0; base = 10; neg = 0; upper = 0; ptr = 0;
    alt = r.alternate;
    w = clip_field(r.width);
    prec = clip_field(r.precision);
    if (r.func > FUNC_P) return;
    if (r.func == FUNC_P) begin
      if (PDIG < 16) v &= (64'd1 << (4 * PDIG)) - 64'd1;
      ptr = 1; base = 16; prec = PDIG; alt = 1; w = 0;
    end else begin
      if (!r.wide) v &= 64'hFFFF_FFFF;
      if (r.func == FUNC_X || r.func == FUNC_UX) base = 16;
      else if (r.func == FUNC_O) base = 8;
      upper = (r.func == FUNC_UX);
      if (r.func == FUNC_D && (r.wide ? v[63] : v[31])) begin
        neg = 1;
        v = 64'd0 - v;
        if (!r.wide) v &= 64'hFFFF_FFFF;
      end
    end
    do begin
      d = 8'(v % base);
      body[n++] = (d < 10) ? CH_ZERO + d : (upper ? CH_UA10 : CH_LA10) + d;
      v = v / base;
    end while (v != 0 && n < 64);
    if (prec != 0) begin
      while (n < prec) body[n++] = CH_ZERO;
    end else if (w != 0 && r.zero_fill) begin
      target = w;
      if (alt) begin
        if (base == 16) target -= 2;
        else if (base == 8) target -= 1;
      end
      if (neg) target -= 1;
      while (n < target) body[n++] = CH_ZERO;
    end
    if (alt) begin
      if (base == 8) body[n++] = CH_ZERO;
      else if (base == 16) begin
        body[n++] = upper ? CH_UX : CH_LX;
        body[n++] = CH_ZERO;
      end
    end
    if (neg) body[n++] = CH_MINUS;
    else if (r.sign_mode == SMODE_PLUS) body[n++] = CH_PLUS;
    else if (r.sign_mode == SMODE_SPACE) body[n++] = CH_SPACE;
    if (!ptr && w > n) pad = w - n;
    k0 = expected_chars.size();
    c.last = 1'b0;
    if (!r.left_align)
      for (int i = 0; i < pad; i++) begin c.char_out = CH_SPACE; expected_chars.push_back(c); end
    for (int i = n - 1; i >= 0; i--) begin c.char_out = body[i]; expected_chars.push_back(c); end
    if (r.left_align)
      for (int i = 0; i < pad; i++) begin c.char_out = CH_SPACE; expected_chars.push_back(c); end
    if (expected_chars.size() > k0) expected_chars[$].last = 1'b1;
  endtask

  // Typed-in text expectation.
  task automatic text_chars(input string s);
    res_word_t c;
    for (int i = 0; i < s.len(); i++) begin
      c.char_out = s[i];
      c.last = (i == s.len() - 1);
      expected_chars.push_back(c);
    end
  endtask

  function automatic req_word_t mk(input logic [2:0] f, input logic [63:0] v, input bit wd,
                                   input bit al, input bit la, input logic [1:0] sm,
                                   input bit zp, input logic [4:0] w, input logic [4:0] p);
    req_word_t r;
    r.func = f; r.value = v; r.wide = wd; r.alternate = al; r.left_align = la;
    r.sign_mode = sm; r.zero_fill = zp; r.width = w; r.precision = p;
    return r;
  endfunction

  function automatic req_word_t rand_req();
    req_word_t r;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    r = raw[$bits(req_word_t)-1:0];
    r.func = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    // mostly small sizes, some full
    if ($urandom_range(0, 3) != 0) r.width = 5'($urandom_range(0, 12));
    if ($urandom_range(0, 2) != 0) r.precision = ($urandom_range(0, 1)) ? 5'd0
                                                  : 5'($urandom_range(1, 10));
    case ($urandom_range(0, 5))
      0: r.value = 64'($urandom_range(0, 20));
      1: r.value = {32'hFFFF_FFFF, 32'($urandom_range(0, 3)) ^ 32'hFFFF_FFFF};
      2: r.value = {$urandom, 32'h8000_0000};
      default: ;
    endcase
    return r;
  endfunction

  task automatic offer(input req_word_t r, input string txt);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (txt.len() != 0) text_chars(txt);
    else format_chars(r);
  endtask

  row_t rows[$];

  initial begin
    rows = '{
      '{mk(FUNC_D, 64'd0, 0, 0, 0, 0, 0, 0, 0), "0"},
      '{mk(FUNC_D, 64'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0), "-1"},
      '{mk(FUNC_D, 64'h8000_0000, 0, 0, 0, 0, 0, 0, 0), "-2147483648"},
      '{mk(FUNC_D, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0, 0, 0), "-9223372036854775808"},
      '{mk(FUNC_U, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 0, 0), "18446744073709551615"},
      '{mk(FUNC_U, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 1, 0, 0, 0), "+4294967295"},
      '{mk(FUNC_X, 64'd255, 0, 1, 0, 0, 0, 0, 0), "0xff"},
      '{mk(FUNC_UX, 64'd255, 0, 1, 0, 0, 0, 0, 0), "0XFF"},
      '{mk(FUNC_O, 64'd8, 0, 1, 0, 0, 0, 0, 0), "010"},
      '{mk(FUNC_O, 64'd0, 0, 1, 0, 0, 0, 0, 0), "00"},
      '{mk(FUNC_X, 64'd0, 0, 1, 0, 0, 0, 0, 0), "0x0"},
      '{mk(FUNC_P, 64'h1234, 0, 0, 1, 0, 1, 5'd20, 5'd3), "0x0000000000001234"},
      '{mk(FUNC_P, 64'd1, 1, 0, 0, SMODE_PLUS, 0, 0, 0), "+0x0000000000000001"},
      '{mk(3'd6, 64'd5, 0, 0, 0, 0, 0, 5'd4, 0), ""},
      '{mk(3'd7, 64'd5, 1, 1, 1, 3, 1, 5'd31, 5'd31), ""},
      '{mk(FUNC_D, 64'd42, 0, 0, 0, 3, 0, 5'd4, 0), "  42"},
      '{mk(FUNC_D, 64'd42, 0, 0, 1, SMODE_SPACE, 0, 5'd5, 0), " 42  "},
      '{mk(FUNC_D, 64'd7, 0, 0, 0, SMODE_PLUS, 1, 5'd4, 0), "+0007"},
      '{mk(FUNC_D, 64'hFFFF_FFF9, 0, 0, 0, 0, 1, 5'd4, 0), "-007"},
      '{mk(FUNC_U, 64'd1, 0, 0, 0, 0, 0, 5'd31, 0), ""},
      '{mk(FUNC_U, 64'd1, 0, 0, 1, 0, 0, 5'd1, 5'd31), ""},
      '{mk(FUNC_X, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 1, 0, 1, 5'd28, 0), ""},
      '{mk(FUNC_O, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0, SMODE_PLUS, 0, 5'd31, 5'd0), ""},
      '{mk(FUNC_D, 64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 0, 0, 5'd28, 5'd28), ""}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      // unused kinds have an empty text and no predicted chars either way
      offer(rows[i].r, rows[i].txt);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) hold_long = 1;
      offer(rand_req(), "");
    end
    req_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall: random per word, plus one long hold-off.
  initial begin
    int wait_n;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        res_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 0;
      end else begin
        wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        if (wait_n != 0) begin
          res_stall <= 1'b1;
          repeat (wait_n) @(posedge clk);
        end
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  // Scoreboard: compare each accepted char with the oldest expected one.
  always @(posedge clk) begin
    res_word_t e;
    if (!rst && res_valid && !res_stall) begin
      if (expected_chars.size() == 0) report($sformatf("unexpected char %h", res.char_out));
      else begin
        e = expected_chars.pop_front();
        if (res.char_out !== e.char_out)
          report($sformatf("char %h, want %h", res.char_out, e.char_out));
        if (res.last !== e.last)
          report($sformatf("last %b, want %b", res.last, e.last));
      end
    end
  end

  // End of run and timeout.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stim_done && expected_chars.size() == 0) begin
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_chars.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          if (expected_chars.size() != 0) report("expected chars left over");
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end

endmodule
